>>> sv/ole_pkg.sv
// Package for the ordered list engine: capacity, widths, operation and status codes,
// and the control struct that the engine broadcasts to its cells.
// Used by ole_cell and ordered_list_engine; depends on nothing.
`default_nettype none

package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 9;
	localparam int STAT_W   = 2;
	localparam int ECNT_W   = 9;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] at;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/ole_cell.sv
// One list cell: holds a single entry and shifts toward or away from the front.
// Depends on ole_pkg for the widths and the broadcast control struct.
`default_nettype none

module ole_cell (
	input  wire logic                      clk,
	input  wire ole_pkg::cell_ctl_t        ctl,
	input  wire logic [ole_pkg::IDX_W-1:0] idx,
	input  wire logic [ole_pkg::VAL_W-1:0] ins_val,
	input  wire logic [ole_pkg::VAL_W-1:0] left_val,
	input  wire logic [ole_pkg::VAL_W-1:0] right_val,
	output logic      [ole_pkg::VAL_W-1:0] entry
);
	import ole_pkg::*;

	logic [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (idx > ctl.at)) begin
			entry_q <= left_val;
		end else if (ctl.ins && (idx == ctl.at)) begin
			entry_q <= ins_val;
		end else if (ctl.del && (idx >= ctl.at)) begin
			entry_q <= right_val;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

>>> sv/ordered_list_engine.sv
// Top level of the ordered list engine: command decode, entry count, the row of cells
// and the registered result beat. Depends on ole_pkg and ole_cell.
`default_nettype none

// The list lives in a row of CAPACITY cells, front at cell zero. An insert or delete
// moves every affected cell by one place in the same clock, so one command beat is
// taken per cycle and its result beat appears in the cycle after it is accepted. The
// single output register is the only limit: a new command is taken whenever that
// register is empty or its beat is being taken in the same cycle.
module ordered_list_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: operation[2:0], value[34:3], position[43:35], zero fill.
	input  wire logic [ole_pkg::IN_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// Fields from bit 0: status[1:0], removed_value[33:2], entry_count[42:34],
	// is_empty[43], zero fill.
	output logic      [ole_pkg::OUT_W-1:0] m_tdata
);
	import ole_pkg::*;

	logic [OP_W-1:0]  operation;
	logic [VAL_W-1:0] value;
	logic [POS_W-1:0] position;
	logic             accept;
	logic             pos_neg;
	logic [8:0]       pos_mag;
	logic [8:0]       cnt9;
	logic [8:0]       at9;
	logic             full;
	logic             empty;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	status_t          status;
	cell_ctl_t        ctl;
	logic [VAL_W-1:0] removed;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [VAL_W-1:0] entries [CAPACITY];

	assign operation = s_tdata[2:0];
	assign value     = s_tdata[34:3];
	assign position  = s_tdata[43:35];
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign pos_neg   = position[8];
	assign pos_mag   = {1'b0, position[7:0]};
	assign cnt9      = 9'(count_q);
	assign full      = (cnt9 >= 9'(CAPACITY));
	assign empty     = (count_q == '0);

	always_comb begin
		status = ST_OK;
		at9    = '0;
		ctl    = '0;
		unique case (operation)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				if (operation == OP_INS_FRONT) begin
					at9 = '0;
				end else if (operation == OP_INS_BACK) begin
					at9 = cnt9;
				end else begin
					at9 = (pos_mag > cnt9) ? cnt9 : pos_mag;
				end
				if ((operation == OP_INS_POS) && pos_neg) begin
					status = ST_BADPOS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
				if (operation == OP_DEL_FRONT) begin
					at9 = '0;
				end else if (operation == OP_DEL_BACK) begin
					at9 = cnt9 - 9'd1;
				end else begin
					at9 = pos_mag;
				end
				if ((operation == OP_DEL_POS) && pos_neg) begin
					status = ST_BADPOS;
				end else if (empty) begin
					status = ST_EMPTY;
				end else if (at9 >= cnt9) begin
					status = ST_BADPOS;
				end else begin
					ctl.del = 1'b1;
				end
			end
			default: begin
				status = ST_BADPOS;
			end
		endcase
		ctl.at  = at9[IDX_W-1:0];
		ctl.ins = ctl.ins && accept;
		ctl.del = ctl.del && accept;
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (ctl.del && (IDX_W'(i) == ctl.at)) begin
				removed = removed | entries[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.del) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VAL_W-1:0] left_val;
		logic [VAL_W-1:0] right_val;
		if (g == 0) begin : g_first
			assign left_val = entries[g];
		end else begin : g_inner_l
			assign left_val = entries[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_val = entries[g];
		end else begin : g_inner_r
			assign right_val = entries[g+1];
		end
		ole_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(g)),
			.ins_val   (value),
			.left_val  (left_val),
			.right_val (right_val),
			.entry     (entries[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {4'b0, (count_next == '0), ECNT_W'(count_next), removed, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(count_q) <= 9'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted command produced no result beat");

	a_count_matches_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tdata[42:34] == 9'(count_q)) && (m_tdata[43] == (count_q == '0)))
		else $error("reported entry count disagrees with the stored count");

	a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (status == ST_FULL)) |-> (9'(count_q) == 9'(CAPACITY)))
		else $error("full status reported below capacity");

	a_no_ins_and_del: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.del))
		else $error("insert and delete issued together");
`endif

endmodule

`default_nettype wire

>>> tb/ordered_list_engine_test.sv
// Self-checking testbench for ordered_list_engine: directed table then random insert and
// delete bursts, checked beat by beat against an in-bench model of the bounded list.
// Depends on ole_pkg and the ordered_list_engine RTL.
`default_nettype none

module ordered_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ole_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 340;
	localparam int DIRECTED_ROWS = 25;

	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  removed;
		logic [ECNT_W-1:0] count;
		logic              empty;
	} list_result_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		logic             known;
		list_result_t     want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	logic              row_known = 1'b0;
	list_result_t      row_want = '0;

	logic [VAL_W-1:0]  list_words [CAPACITY];
	int unsigned       list_len = 0;
	list_result_t      pending_results [$];
	int                mismatches = 0;
	int                quiet_cycles = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                hold_left = 0;
	stim_row_t         directed_rows [DIRECTED_ROWS];

	ordered_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic list_result_t apply_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
			logic [POS_W-1:0] position);
		list_result_t r;
		int unsigned  at;
		int           i;
		r.status  = ST_OK;
		r.removed = '0;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				if (op == OP_INS_POS && position[POS_W-1]) begin
					r.status = ST_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					if (op == OP_INS_FRONT)
						at = 0;
					else if (op == OP_INS_BACK)
						at = list_len;
					else
						at = (position[POS_W-2:0] > list_len) ? list_len : position[POS_W-2:0];
					for (i = list_len; i > at; i--)
						list_words[i] = list_words[i-1];
					list_words[at] = value;
					list_len++;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
				if (op == OP_DEL_POS && position[POS_W-1]) begin
					r.status = ST_BADPOS;
				end else if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == OP_DEL_FRONT)
						at = 0;
					else if (op == OP_DEL_BACK)
						at = list_len - 1;
					else
						at = position[POS_W-2:0];
					if (at >= list_len) begin
						r.status = ST_BADPOS;
					end else begin
						r.removed = list_words[at];
						for (i = at; i + 1 < list_len; i++)
							list_words[i] = list_words[i+1];
						list_len--;
					end
				end
			end
			default: r.status = ST_BADPOS;
		endcase
		r.count = list_len[ECNT_W-1:0];
		r.empty = (list_len == 0);
		return r;
	endfunction

	function automatic logic [IN_W-1:0] pack_cmd(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
			logic [POS_W-1:0] position);
		return {{(IN_W-OP_W-VAL_W-POS_W){1'b0}}, position, value, op};
	endfunction

	function automatic logic [IN_W-1:0] random_cmd(bit filling);
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 5)
			op = OP_W'($urandom_range(7));
		else if (pick < 80)
			op = filling ? OP_W'($urandom_range(2)) : OP_W'(3 + $urandom_range(2));
		else
			op = filling ? OP_W'(3 + $urandom_range(2)) : OP_W'($urandom_range(2));
		case ($urandom_range(9))
			0: value = 32'h7FFF_FFFF;
			1: value = 32'h8000_0000;
			default: value = $urandom;
		endcase
		pick = $urandom_range(99);
		if (pick < 75)
			position = POS_W'($urandom_range(CAPACITY + 1));
		else if (pick < 85)
			position = POS_W'(32'h100 | $urandom_range(255));
		else
			position = POS_W'($urandom_range(511));
		return pack_cmd(op, value, position);
	endfunction

	task automatic report_mismatch(string what, list_result_t want, list_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected status %0d removed %h count %0d empty %0b,",
				$realtime, what, want.status, want.removed, want.count, want.empty,
				" got status %0d removed %h count %0d empty %0b",
				got.status, got.removed, got.count, got.empty);
	endtask

	always @(posedge clk) begin : scoreboard
		list_result_t got;
		list_result_t want;
		list_result_t predicted;
		if (m_tvalid && m_tready) begin
			got.status  = status_t'(m_tdata[1:0]);
			got.removed = m_tdata[33:2];
			got.count   = m_tdata[42:34];
			got.empty   = m_tdata[43];
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with none outstanding", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.removed !== want.removed ||
						got.count !== want.count || got.empty !== want.empty)
					report_mismatch("result mismatch", want, got);
			end
		end
		if (s_tvalid && s_tready) begin
			predicted = apply_command(s_tdata[2:0], s_tdata[34:3], s_tdata[43:35]);
			pending_results.push_back(row_known ? row_want : predicted);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_cmd(input logic [IN_W-1:0] cmd, input logic known, input list_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= cmd;
		row_known <= known;
		row_want  <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int items);
		int  burst_left;
		bit  filling;
		burst_left = 0;
		filling = 1'b0;
		for (int k = 0; k < items; k++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(10, 40);
				filling = !filling;
			end
			burst_left--;
			send_cmd(random_cmd(filling), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		directed_rows = '{
			'{OP_DEL_FRONT, 32'd0, 9'd0, 1'b1, '{ST_EMPTY, 32'd0, 9'd0, 1'b1}},
			'{OP_DEL_BACK, 32'd0, 9'd0, 1'b1, '{ST_EMPTY, 32'd0, 9'd0, 1'b1}},
			'{OP_DEL_POS, 32'd0, 9'd0, 1'b1, '{ST_EMPTY, 32'd0, 9'd0, 1'b1}},
			'{OP_DEL_POS, 32'd0, 9'h1FF, 1'b1, '{ST_BADPOS, 32'd0, 9'd0, 1'b1}},
			'{OP_INS_POS, 32'd5, 9'h100, 1'b1, '{ST_BADPOS, 32'd0, 9'd0, 1'b1}},
			'{OP_SPARE_A, 32'd7, 9'd0, 1'b1, '{ST_BADPOS, 32'd0, 9'd0, 1'b1}},
			'{OP_SPARE_B, 32'd7, 9'd0, 1'b1, '{ST_BADPOS, 32'd0, 9'd0, 1'b1}},
			'{OP_INS_FRONT, 32'h7FFF_FFFF, 9'd0, 1'b1, '{ST_OK, 32'd0, 9'd1, 1'b0}},
			'{OP_INS_BACK, 32'h8000_0000, 9'd0, 1'b1, '{ST_OK, 32'd0, 9'd2, 1'b0}},
			'{OP_INS_POS, 32'hFFFF_FFFF, 9'd255, 1'b1, '{ST_OK, 32'd0, 9'd3, 1'b0}},
			'{OP_INS_POS, 32'd0, 9'd1, 1'b1, '{ST_OK, 32'd0, 9'd4, 1'b0}},
			'{OP_INS_POS, 32'd1, 9'd0, 1'b1, '{ST_OK, 32'd0, 9'd5, 1'b0}},
			'{OP_DEL_POS, 32'd0, 9'd5, 1'b1, '{ST_BADPOS, 32'd0, 9'd5, 1'b0}},
			'{OP_DEL_POS, 32'd0, 9'd255, 1'b1, '{ST_BADPOS, 32'd0, 9'd5, 1'b0}},
			'{OP_DEL_POS, 32'hFFFF_FFFF, 9'd2, 1'b0, '0},
			'{OP_DEL_FRONT, 32'd0, 9'd0, 1'b1, '{ST_OK, 32'd1, 9'd3, 1'b0}},
			'{OP_DEL_BACK, 32'd0, 9'd0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 9'd2, 1'b0}},
			'{OP_DEL_POS, 32'd0, 9'd1, 1'b0, '0},
			'{OP_INS_POS, 32'hA5A5_A5A5, 9'd0, 1'b0, '0},
			'{OP_DEL_BACK, 32'd0, 9'd0, 1'b0, '0},
			'{OP_DEL_FRONT, 32'd0, 9'd0, 1'b1, '{ST_OK, 32'hA5A5_A5A5, 9'd0, 1'b1}},
			'{OP_DEL_BACK, 32'd0, 9'd0, 1'b1, '{ST_EMPTY, 32'd0, 9'd0, 1'b1}},
			'{OP_INS_POS, 32'hDEAD_BEEF, 9'd255, 1'b1, '{ST_OK, 32'd0, 9'd1, 1'b0}},
			'{OP_DEL_POS, 32'd0, 9'h100, 1'b1, '{ST_BADPOS, 32'd0, 9'd1, 1'b0}},
			'{OP_DEL_POS, 32'd0, 9'd0, 1'b0, '0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(pack_cmd(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].position), directed_rows[i].known, directed_rows[i].want);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 26 : 0;
			recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 26 : 0;
			run_random(ITEMS_PER_PHASE);
			wait_drained();
		end

		// Hold the result side off so the single output register fills and input backs up.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 60;
		run_random(40);
		wait_drained();

		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
